>>> design/srbs_pkg.sv
// ----------------------------------------------------------------------------
// srbs_pkg
// shared types and constants for the stable rarity bucket sort
// ----------------------------------------------------------------------------
package srbs_pkg;

    localparam int SLOTS       = 32;
    localparam int RANK_LEVELS = 5;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int KEY_W       = 3;
    localparam int CODE_W      = 16;
    localparam int QTY_W       = 16;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [QTY_W-1:0]  count;
        logic [KEY_W-1:0]  key;
        logic              empty;
    } slot_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_FILL
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic wr_slot;
        logic start_run;
        logic idx_next;
        logic key_next;
        logic emit_item;
        logic emit_fill;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_last;
        logic idx_at_end;
        logic key_at_end;
        logic hit;
        logic out_free;
        logic emit_final;
    } sts_t;

endpackage

>>> design/srbs_ctrl.sv
// ----------------------------------------------------------------------------
// srbs_ctrl
// sequencer for table load, per-key scan and filler emission
// ----------------------------------------------------------------------------
module srbs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  srbs_pkg::sts_t  sts,
    output srbs_pkg::cmd_t  cmd
);

    srbs_pkg::state_t state_reg;
    srbs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srbs_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            srbs_pkg::ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.wr_slot = 1'b1;
                    if (sts.in_last)
                    begin
                        cmd.start_run = 1'b1;
                        state_next    = srbs_pkg::ST_SCAN_RD;
                    end
                end
            end
            srbs_pkg::ST_SCAN_RD:
            begin
                // read data lands in the next cycle
                state_next = srbs_pkg::ST_SCAN_EV;
            end
            srbs_pkg::ST_SCAN_EV:
            begin
                if (!sts.hit || sts.out_free)
                begin
                    cmd.emit_item = sts.hit;
                    if (sts.hit && sts.emit_final)
                    begin
                        state_next = srbs_pkg::ST_LOAD;
                    end
                    else if (sts.idx_at_end)
                    begin
                        if (sts.key_at_end)
                        begin
                            state_next = srbs_pkg::ST_FILL;
                        end
                        else
                        begin
                            cmd.key_next = 1'b1;
                            state_next   = srbs_pkg::ST_SCAN_RD;
                        end
                    end
                    else
                    begin
                        cmd.idx_next = 1'b1;
                        state_next   = srbs_pkg::ST_SCAN_RD;
                    end
                end
            end
            srbs_pkg::ST_FILL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_fill = 1'b1;
                    if (sts.emit_final)
                    begin
                        state_next = srbs_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = srbs_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

>>> design/srbs_datapath.sv
// ----------------------------------------------------------------------------
// srbs_datapath
// slot store, scan counters and output register
// ----------------------------------------------------------------------------
module srbs_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  srbs_pkg::cmd_t                 cmd,
    output srbs_pkg::sts_t                 sts,
    input  logic [srbs_pkg::CODE_W-1:0]    item_code,
    input  logic [srbs_pkg::QTY_W-1:0]     item_count,
    input  logic [srbs_pkg::KEY_W-1:0]     rank_key,
    input  logic                           slot_empty,
    input  logic                           is_last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [srbs_pkg::CODE_W-1:0]    out_code,
    output logic [srbs_pkg::QTY_W-1:0]     out_count,
    output logic                           out_empty,
    output logic                           out_last
);

    srbs_pkg::slot_t mem [srbs_pkg::SLOTS];
    srbs_pkg::slot_t rd_data_reg;

    logic [srbs_pkg::IDX_W-1:0] loaded_reg;
    logic [srbs_pkg::CNT_W-1:0] total_reg;
    logic [srbs_pkg::IDX_W-1:0] idx_reg;
    logic [srbs_pkg::KEY_W-1:0] key_reg;
    logic [srbs_pkg::CNT_W-1:0] emitted_reg;

    logic                        out_valid_reg;
    logic [srbs_pkg::CODE_W-1:0] out_code_reg;
    logic [srbs_pkg::QTY_W-1:0]  out_count_reg;
    logic                        out_empty_reg;
    logic                        out_last_reg;

    logic [srbs_pkg::CNT_W-1:0] loaded_plus1;
    logic [srbs_pkg::CNT_W-1:0] idx_plus1;
    logic [srbs_pkg::CNT_W-1:0] emitted_plus1;

    assign loaded_plus1  = srbs_pkg::CNT_W'(loaded_reg) + 1'b1;
    assign idx_plus1     = srbs_pkg::CNT_W'(idx_reg) + 1'b1;
    assign emitted_plus1 = emitted_reg + 1'b1;

    assign sts.in_last    = is_last || (loaded_plus1 == srbs_pkg::CNT_W'(srbs_pkg::SLOTS));
    assign sts.idx_at_end = (idx_plus1 == total_reg);
    assign sts.key_at_end = (key_reg == srbs_pkg::KEY_W'(srbs_pkg::RANK_LEVELS - 1));
    assign sts.hit        = !rd_data_reg.empty && (rd_data_reg.key == key_reg);
    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign sts.emit_final = (emitted_plus1 == total_reg);

    // slot store
    always_ff @(posedge clk)
    begin
        if (cmd.wr_slot)
        begin
            mem[loaded_reg] <= '{code: item_code, count: item_count,
                                 key: rank_key, empty: slot_empty};
        end
        rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg  <= '0;
            total_reg   <= '0;
            idx_reg     <= '0;
            key_reg     <= '0;
            emitted_reg <= '0;
        end
        else
        begin
            if (cmd.wr_slot)
            begin
                if (cmd.start_run)
                begin
                    loaded_reg <= '0;
                    total_reg  <= loaded_plus1;
                end
                else
                begin
                    loaded_reg <= loaded_reg + 1'b1;
                end
            end
            if (cmd.start_run)
            begin
                idx_reg     <= '0;
                key_reg     <= '0;
                emitted_reg <= '0;
            end
            else
            begin
                if (cmd.idx_next)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                else if (cmd.key_next)
                begin
                    idx_reg <= '0;
                    key_reg <= key_reg + 1'b1;
                end
                if (cmd.emit_item || cmd.emit_fill)
                begin
                    emitted_reg <= emitted_plus1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_item || cmd.emit_fill)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_item)
        begin
            out_code_reg  <= rd_data_reg.code;
            out_count_reg <= rd_data_reg.count;
            out_empty_reg <= 1'b0;
            out_last_reg  <= sts.emit_final;
        end
        else if (cmd.emit_fill)
        begin
            out_code_reg  <= '0;
            out_count_reg <= '0;
            out_empty_reg <= 1'b1;
            out_last_reg  <= sts.emit_final;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_code  = out_code_reg;
    assign out_count = out_count_reg;
    assign out_empty = out_empty_reg;
    assign out_last  = out_last_reg;

endmodule

>>> design/stable_rarity_bucket_sort.sv
// ----------------------------------------------------------------------------
// stable_rarity_bucket_sort
// stable bucket sort of an item table by rank key
// ----------------------------------------------------------------------------
// input channel: one table slot per request (in_valid/in_stall). slots load
// one per cycle; the slot with is_last, or the 32nd slot, closes the table.
// while the table is being sorted in_stall stays high.
// output channel: one sorted slot per request (out_valid/out_stall), as many
// as were loaded. items come by rank key 0 to 4, load order kept within a
// key; empty slots and keys 5 to 7 are dropped and replaced by empty fillers
// at the tail. out_last marks the final slot of the run.
// scan: at the earliest, the first sorted slot follows the last input slot
// through the scan read state, the compare state and the output register.
// the sort walks the slot store once per key, each slot by a store read,
// then a compare; the empty fillers are emitted after the last key.
// a stalled output holds the scan at a matching slot; loading of the next
// table starts as soon as the last sorted slot sits in the output register.
// reset clears the controller, counters and output valid; the store needs
// no clearing.
// ----------------------------------------------------------------------------
module stable_rarity_bucket_sort (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [srbs_pkg::CODE_W-1:0]    item_code,
    input  logic [srbs_pkg::QTY_W-1:0]     item_count,
    input  logic [srbs_pkg::KEY_W-1:0]     rank_key,
    input  logic                           slot_empty,
    input  logic                           is_last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [srbs_pkg::CODE_W-1:0]    out_code,
    output logic [srbs_pkg::QTY_W-1:0]     out_count,
    output logic                           out_empty,
    output logic                           out_last
);

    srbs_pkg::cmd_t cmd;
    srbs_pkg::sts_t sts;

    srbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    srbs_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .item_code  (item_code),
        .item_count (item_count),
        .rank_key   (rank_key),
        .slot_empty (slot_empty),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_code   (out_code),
        .out_count  (out_count),
        .out_empty  (out_empty),
        .out_last   (out_last)
    );

endmodule
